FILE: rtl/core/sveu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveu_pkg: shared types and constants for the scalar/vector execute unit
// Opcode codes, ALU operation codes and the ALU command/result structs.
// ----------------------------------------------------------------------------
package sveu_pkg;

  localparam int NUM_SCALAR_REGS_DEF = 256;
  localparam int NUM_VECTOR_REGS_DEF = 32;
  localparam int VECTOR_LANES_DEF    = 8;

  localparam logic [7:0] OP_ADD_R   = 8'd0;
  localparam logic [7:0] OP_SUB_R   = 8'd1;
  localparam logic [7:0] OP_ADD_C   = 8'd2;
  localparam logic [7:0] OP_SUB_C   = 8'd3;
  localparam logic [7:0] OP_MUL_R   = 8'd4;
  localparam logic [7:0] OP_MUL_C   = 8'd5;
  localparam logic [7:0] OP_DIV_R   = 8'd6;
  localparam logic [7:0] OP_DIV_C   = 8'd7;
  localparam logic [7:0] OP_MOV_C   = 8'd8;
  localparam logic [7:0] OP_MOV_R   = 8'd9;
  localparam logic [7:0] OP_REPORT  = 8'd10;
  localparam logic [7:0] OP_VEC_LO  = 8'd11;
  localparam logic [7:0] OP_VEC_VHI = 8'd13;
  localparam logic [7:0] OP_VEC_CHI = 8'd16;
  localparam logic [7:0] OP_VEC_HI  = 8'd19;
  localparam logic [7:0] OP_HALT    = 8'd20;
  localparam logic [7:0] OP_BR_LO   = 8'd21;
  localparam logic [7:0] OP_BR_HI   = 8'd35;

  // individual vector opcodes: with a vector, a constant or a scalar register
  localparam logic [7:0] OP_VADD_V  = 8'd11;
  localparam logic [7:0] OP_VSUB_V  = 8'd12;
  localparam logic [7:0] OP_VMUL_V  = 8'd13;
  localparam logic [7:0] OP_VADD_C  = 8'd14;
  localparam logic [7:0] OP_VSUB_C  = 8'd15;
  localparam logic [7:0] OP_VMUL_C  = 8'd16;
  localparam logic [7:0] OP_VADD_S  = 8'd17;
  localparam logic [7:0] OP_VSUB_S  = 8'd18;
  localparam logic [7:0] OP_VMUL_S  = 8'd19;

  // branch condition codes (opcode minus OP_BR_LO)
  localparam logic [3:0] CC_EQ = 4'd0;
  localparam logic [3:0] CC_NE = 4'd1;
  localparam logic [3:0] CC_CS = 4'd2;
  localparam logic [3:0] CC_CC = 4'd3;
  localparam logic [3:0] CC_MI = 4'd4;
  localparam logic [3:0] CC_PL = 4'd5;
  localparam logic [3:0] CC_VS = 4'd6;
  localparam logic [3:0] CC_VC = 4'd7;
  localparam logic [3:0] CC_HI = 4'd8;
  localparam logic [3:0] CC_LS = 4'd9;
  localparam logic [3:0] CC_GE = 4'd10;
  localparam logic [3:0] CC_LT = 4'd11;
  localparam logic [3:0] CC_GT = 4'd12;
  localparam logic [3:0] CC_LE = 4'd13;
  localparam logic [3:0] CC_AL = 4'd14;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
    logic [3:0]  flags;   // Z N C V
  } alu_rsp_t;

  function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
    logic z, n, c, v, r;
    z = f[3]; n = f[2]; c = f[1]; v = f[0];
    case (cc)
      CC_EQ:   r = z;
      CC_NE:   r = !z;
      CC_CS:   r = c;
      CC_CC:   r = !c;
      CC_MI:   r = n;
      CC_PL:   r = !n;
      CC_VS:   r = v;
      CC_VC:   r = !v;
      CC_HI:   r = c && !z;
      CC_LS:   r = !c || z;
      CC_GE:   r = n == v;
      CC_LT:   r = n != v;
      CC_GT:   r = !z && (n == v);
      CC_LE:   r = z || (n != v);
      CC_AL:   r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/sveu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveu_alu: shared arithmetic unit
// Add/sub with flags and multiply are combinational; signed divide one quotient
// bit per cycle (restoring, sign fixed at the output). Divisor must be nonzero.
// ----------------------------------------------------------------------------
module sveu_alu (
  input  logic                clk,
  input  logic                rst,
  input  sveu_pkg::alu_cmd_t  cmd,
  output sveu_pkg::alu_rsp_t  rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] quo, rem, dvs;
  logic        neg;
  logic [32:0] sum;
  logic [31:0] ma, mb;
  logic [32:0] trial;

  assign ma = cmd.a[31] ? 32'd0 - cmd.a : cmd.a;
  assign mb = cmd.b[31] ? 32'd0 - cmd.b : cmd.b;
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  // combinational add/sub
  always_comb begin
    sum = (cmd.op == sveu_pkg::ALU_SUB) ? {1'b0, cmd.a} - {1'b0, cmd.b}
                                       : {1'b0, cmd.a} + {1'b0, cmd.b};
  end

  // restoring divider iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start && cmd.op == sveu_pkg::ALU_DIV) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      quo  <= ma;
      rem  <= '0;
      dvs  <= mb;
      neg  <= cmd.a[31] ^ cmd.b[31];
    end else if (busy && cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end else begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    rsp = '0;
    case (cmd.op)
      sveu_pkg::ALU_ADD, sveu_pkg::ALU_SUB: begin
        rsp.done     = cmd.start;
        rsp.res      = sum[31:0];
        rsp.flags[3] = sum[31:0] == 32'd0;
        rsp.flags[2] = sum[31];
        if (cmd.op == sveu_pkg::ALU_ADD) begin
          rsp.flags[1] = sum[32];
          rsp.flags[0] = (cmd.a[31] == cmd.b[31]) && (sum[31] != cmd.a[31]);
        end else begin
          rsp.flags[1] = cmd.a > cmd.b;
          rsp.flags[0] = (cmd.a[31] != cmd.b[31]) && (sum[31] == cmd.b[31]);
        end
      end
      sveu_pkg::ALU_MUL: begin
        rsp.done = cmd.start;
        rsp.res  = cmd.a * cmd.b;
      end
      default: begin
        rsp.done = busy && cnt == 6'd0;
        rsp.res  = neg ? 32'd0 - quo : quo;
      end
    endcase
  end

endmodule

FILE: rtl/core/scalar_vector_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_vector_execute_unit: sequenced scalar/vector instruction executor
// Executes one 4-byte instruction on a scalar file, vector file, pc and flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one instruction item: req_type,
//   dest_field, src1_field, src2_field. in_stall is low only in the idle
//   state, so one item is in work at a time. Output channel (out_valid/
//   out_stall) delivers one result item per instruction: next pc, print info,
//   halt and error bits, and the ZNCV flags after the instruction.
//   After reset a clearing pass zeroes both register files, its counter
//   running up to max(NUM_SCALAR_REGS, NUM_VECTOR_REGS * VECTOR_LANES).
//   Move, print, branch, halt and any item while halted go from the read
//   state straight to done; add, subtract, multiply and a zero divisor pass
//   through execute; divide waits on the divider, which resolves one quotient
//   bit a cycle; vector ops step through the lanes, one lane per read and
//   execute pass through the shared ALU.
//   After the result is taken the block returns to idle before it accepts
//   the next item, so items never overlap.
//   A result held under out_stall keeps the block from taking the next item.
//   Reset clears pc, flags and the halt bit, and starts the clearing pass.
// ----------------------------------------------------------------------------
module scalar_vector_execute_unit #(
  parameter int NUM_SCALAR_REGS = sveu_pkg::NUM_SCALAR_REGS_DEF,
  parameter int NUM_VECTOR_REGS = sveu_pkg::NUM_VECTOR_REGS_DEF,
  parameter int VECTOR_LANES    = sveu_pkg::VECTOR_LANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  req_type,
  input  logic [7:0]  dest_field,
  input  logic [7:0]  src1_field,
  input  logic [7:0]  src2_field,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic        print_valid,
  output logic [7:0]  print_index,
  output logic signed [31:0] print_value,
  output logic        halted,
  output logic        divide_by_zero,
  output logic        unknown_opcode,
  output logic        zero_flag,
  output logic        negative_flag,
  output logic        carry_flag,
  output logic        overflow_flag
);

  localparam int SW  = $clog2(NUM_SCALAR_REGS);
  localparam int VW  = $clog2(NUM_VECTOR_REGS);
  localparam int LW  = (VECTOR_LANES > 1) ? $clog2(VECTOR_LANES) : 1;
  localparam int VDEPTH = NUM_VECTOR_REGS * VECTOR_LANES;
  localparam int VAW = $clog2(VDEPTH);
  localparam int CLR = (NUM_SCALAR_REGS > VDEPTH) ? NUM_SCALAR_REGS : VDEPTH;
  localparam int CW  = $clog2(CLR + 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_RD     = 9'b000000100,
    S_EXEC   = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_VRD    = 9'b000100000,
    S_VEXEC  = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  // memories
  logic [31:0] sregs [NUM_SCALAR_REGS];
  logic [31:0] vregs [VDEPTH];

  logic [CW-1:0] clr_cnt;
  logic [7:0]  op, d8, s1, s2;
  logic [31:0] pc;
  logic [3:0]  flags;
  logic        stop;
  logic [31:0] ra, rb, va, vb;
  logic [LW-1:0] lane;
  logic [VW-1:0] vd_r;

  // write ports
  logic          s_we;
  logic [SW-1:0] s_wa;
  logic [31:0]   s_wd;
  logic          v_we;
  logic [VAW-1:0] v_wa;
  logic [31:0]   v_wd;

  sveu_pkg::alu_cmd_t alu_cmd;
  sveu_pkg::alu_rsp_t alu_rsp;

  sveu_alu u_alu (.clk(clk), .rst(rst), .cmd(alu_cmd), .rsp(alu_rsp));

  // scalar read addresses follow the input fields while idle
  logic [7:0] s1_rd, s2_rd;
  assign s1_rd = (state == S_IDLE) ? src1_field : s1;
  assign s2_rd = (state == S_IDLE) ? src2_field : s2;

  logic is_vec, is_vv, is_vc;
  sveu_pkg::alu_op_t vk;
  assign is_vec = op >= sveu_pkg::OP_VEC_LO && op <= sveu_pkg::OP_VEC_HI;
  assign is_vv  = op <= sveu_pkg::OP_VEC_VHI;
  assign is_vc  = !is_vv && op <= sveu_pkg::OP_VEC_CHI;
  // vector lane operation
  always_comb begin
    case (op)
      sveu_pkg::OP_VADD_V, sveu_pkg::OP_VADD_C, sveu_pkg::OP_VADD_S: vk = sveu_pkg::ALU_ADD;
      sveu_pkg::OP_VSUB_V, sveu_pkg::OP_VSUB_C, sveu_pkg::OP_VSUB_S: vk = sveu_pkg::ALU_SUB;
      default:                                                       vk = sveu_pkg::ALU_MUL;
    endcase
  end

  // branch decision on the current flags
  logic is_br, br_take;
  assign is_br   = op >= sveu_pkg::OP_BR_LO && op <= sveu_pkg::OP_BR_HI;
  assign br_take = is_br && sveu_pkg::cond_holds(4'(op - sveu_pkg::OP_BR_LO), flags);

  function automatic logic [VAW-1:0] vaddr(input logic [7:0] r, input logic [LW-1:0] l);
    logic [VAW:0] t;
    t = (VAW+1)'(r[VW-1:0]) * (VAW+1)'(VECTOR_LANES) + (VAW+1)'(l);
    return t[VAW-1:0];
  endfunction

  // register file reads (registered)
  always_ff @(posedge clk) begin
    ra <= sregs[s1_rd[SW-1:0]];
    rb <= sregs[s2_rd[SW-1:0]];
    va <= vregs[vaddr(s1, lane)];
    vb <= vregs[vaddr(s2, lane)];
  end

  always_ff @(posedge clk) begin
    if (s_we) sregs[s_wa] <= s_wd;
    if (v_we) vregs[v_wa] <= v_wd;
  end

  // ALU command
  always_comb begin
    alu_cmd = '0;
    case (state)
      S_EXEC: begin
        alu_cmd.start = 1'b1;
        alu_cmd.a = ra;
        case (op)
          sveu_pkg::OP_ADD_R: begin alu_cmd.op = sveu_pkg::ALU_ADD; alu_cmd.b = rb; end
          sveu_pkg::OP_ADD_C: begin alu_cmd.op = sveu_pkg::ALU_ADD; alu_cmd.b = {24'd0, s2}; end
          sveu_pkg::OP_SUB_R: begin alu_cmd.op = sveu_pkg::ALU_SUB; alu_cmd.b = rb; end
          sveu_pkg::OP_SUB_C: begin alu_cmd.op = sveu_pkg::ALU_SUB; alu_cmd.b = {24'd0, s2}; end
          sveu_pkg::OP_MUL_R: begin alu_cmd.op = sveu_pkg::ALU_MUL; alu_cmd.b = rb; end
          sveu_pkg::OP_MUL_C: begin alu_cmd.op = sveu_pkg::ALU_MUL; alu_cmd.b = {24'd0, s2}; end
          sveu_pkg::OP_DIV_R: begin alu_cmd.op = sveu_pkg::ALU_DIV; alu_cmd.b = rb; end
          default: begin alu_cmd.op = sveu_pkg::ALU_DIV; alu_cmd.b = {24'd0, s2}; end
        endcase
        if (alu_cmd.op == sveu_pkg::ALU_DIV && alu_cmd.b == 32'd0) alu_cmd.start = 1'b0;
      end
      // keep the divider selected so its done flag shows
      S_DIV: alu_cmd.op = sveu_pkg::ALU_DIV;
      S_VEXEC: begin
        alu_cmd.start = 1'b1;
        alu_cmd.a = va;
        alu_cmd.b = is_vv ? vb : (is_vc ? {24'd0, s2} : rb);
        alu_cmd.op = vk;
      end
      default: alu_cmd = '0;
    endcase
  end

  logic is_scal_alu;
  assign is_scal_alu = op <= sveu_pkg::OP_DIV_C;

  // sequencer
  always_ff @(posedge clk) begin
    s_we <= 1'b0;
    v_we <= 1'b0;
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pc      <= '0;
      flags   <= '0;
      stop    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          s_we <= 1'b1; s_wa <= clr_cnt[SW-1:0]; s_wd <= '0;
          v_we <= 1'b1; v_wa <= clr_cnt[VAW-1:0]; v_wd <= '0;
          // one extra pass so the last write lands before the first read
          if (clr_cnt == CW'(CLR)) state <= S_IDLE;
          clr_cnt <= clr_cnt + CW'(1);
        end
        S_IDLE: if (in_valid) begin
          op <= req_type; d8 <= dest_field; s1 <= src1_field; s2 <= src2_field;
          lane <= '0;
          state <= S_RD;
        end
        S_RD: begin
          print_valid <= 1'b0; print_index <= '0; print_value <= '0;
          divide_by_zero <= 1'b0; unknown_opcode <= 1'b0;
          vd_r <= d8[VW-1:0];
          if (stop) state <= S_DONE;
          else begin
            pc <= br_take ? pc + {{22{s2[7]}}, s2, 2'b00} : pc + 32'd4;
            if (is_scal_alu) state <= S_EXEC;
            else if (is_vec) state <= S_VRD;
            else begin
              state <= S_DONE;
              case (op)
                sveu_pkg::OP_MOV_C: begin s_we <= 1'b1; s_wa <= d8[SW-1:0]; s_wd <= {24'd0, s1}; end
                sveu_pkg::OP_MOV_R: begin s_we <= 1'b1; s_wa <= d8[SW-1:0]; s_wd <= ra; end
                sveu_pkg::OP_REPORT: begin
                  print_valid <= 1'b1; print_index <= s2; print_value <= rb;
                end
                sveu_pkg::OP_HALT: stop <= 1'b1;
                default: begin
                  if (!is_br) begin
                    unknown_opcode <= 1'b1; stop <= 1'b1;
                  end
                end
              endcase
            end
          end
        end
        S_EXEC: begin
          if (alu_cmd.op == sveu_pkg::ALU_DIV) begin
            if (!alu_cmd.start) begin divide_by_zero <= 1'b1; state <= S_DONE; end
            else state <= S_DIV;
          end else begin
            s_we <= 1'b1; s_wa <= d8[SW-1:0]; s_wd <= alu_rsp.res;
            if (alu_cmd.op != sveu_pkg::ALU_MUL) flags <= alu_rsp.flags;
            state <= S_DONE;
          end
        end
        S_DIV: if (alu_rsp.done) begin
          s_we <= 1'b1; s_wa <= d8[SW-1:0]; s_wd <= alu_rsp.res;
          state <= S_DONE;
        end
        S_VRD: state <= S_VEXEC;
        S_VEXEC: begin
          v_we <= 1'b1;
          v_wa <= vaddr({{(8-VW){1'b0}}, vd_r}, lane);
          v_wd <= alu_rsp.res;
          if (32'(lane) == VECTOR_LANES - 1) state <= S_DONE;
          else begin lane <= lane + LW'(1); state <= S_VRD; end
        end
        S_DONE: begin
          // the done state lets the last write land before a next read
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = state != S_IDLE;
  assign next_pc        = pc;
  assign halted         = stop;
  assign zero_flag      = flags[3];
  assign negative_flag  = flags[2];
  assign carry_flag     = flags[1];
  assign overflow_flag  = flags[0];

endmodule

FILE: rtl/core/sveu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sveu_checker: port-level checks for the execute unit
// Watches the handshakes and result bits of the top level.
// ----------------------------------------------------------------------------
module sveu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] next_pc,
  input logic        halted,
  input logic        unknown_opcode,
  input logic        print_valid,
  input logic        divide_by_zero
);

  // a held result keeps its pc
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc))
    else $error("result changed under stall");

  // no new item taken while a result waits
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted with result pending");

  // unknown opcode always reports halted
  a_unk: assert property (@(posedge clk) disable iff (rst)
    out_valid && unknown_opcode |-> halted)
    else $error("unknown opcode without halt");

  // at most one report bit per result
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({print_valid, divide_by_zero, unknown_opcode}))
    else $error("several report bits");

endmodule

bind scalar_vector_execute_unit sveu_checker u_sveu_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
  .halted(halted), .unknown_opcode(unknown_opcode),
  .print_valid(print_valid), .divide_by_zero(divide_by_zero)
);

FILE: verif/scalar_vector_execute_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_vector_execute_unit_test: self-checking bench for the execute unit
// Drives instructions through the valid/stall input channel. A predictor with
// its own register files, pc and flags computes each expected result, and the
// monitor checks each received result field by field. The run has a directed
// opening, then random programs, then a stop. The sender works in bursts and
// the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module scalar_vector_execute_unit_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic [7:0] op;
    logic [7:0] dst;
    logic [7:0] s1;
    logic [7:0] s2;
    bit         drain;   // wait for all results before offering this item
  } instr_t;

  typedef struct packed {
    logic [31:0] pc;
    logic        pv;
    logic [7:0]  pidx;
    logic [31:0] pval;
    logic        hlt;
    logic        dz;
    logic        unk;
    logic        z;
    logic        n;
    logic        c;
    logic        v;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] req_type = '0;
  logic [7:0] dest_field = '0;
  logic [7:0] src1_field = '0;
  logic [7:0] src2_field = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] next_pc;
  logic print_valid;
  logic [7:0] print_index;
  logic signed [31:0] print_value;
  logic halted, divide_by_zero, unknown_opcode;
  logic zero_flag, negative_flag, carry_flag, overflow_flag;

  scalar_vector_execute_unit dut (.*);

  // predictor state
  logic [31:0] sreg [256];
  logic [31:0] vreg [32][8];
  logic [31:0] pc_model;
  logic fz, fn, fc, fv;
  bit   stop_model;

  instr_t   pend_q[$];
  outcome_t expected_q[$];
  int err_count = 0;
  int n_accepted = 0, n_results = 0;
  int n_prints = 0, n_zero_div = 0, n_taken = 0, n_vector = 0;

  initial forever #6 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic bit branch_taken(logic [3:0] cc);
    case (cc)
      sveu_pkg::CC_EQ: return fz;
      sveu_pkg::CC_NE: return !fz;
      sveu_pkg::CC_CS: return fc;
      sveu_pkg::CC_CC: return !fc;
      sveu_pkg::CC_MI: return fn;
      sveu_pkg::CC_PL: return !fn;
      sveu_pkg::CC_VS: return fv;
      sveu_pkg::CC_VC: return !fv;
      sveu_pkg::CC_HI: return fc && !fz;
      sveu_pkg::CC_LS: return !fc || fz;
      sveu_pkg::CC_GE: return fn == fv;
      sveu_pkg::CC_LT: return fn != fv;
      sveu_pkg::CC_GT: return !fz && (fn == fv);
      sveu_pkg::CC_LE: return fz || (fn != fv);
      sveu_pkg::CC_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_flags(logic [31:0] a, logic [31:0] b, logic [31:0] r);
    fz = (r == 0); fn = r[31];
    fc = (r < a) || (r < b);
    fv = (a[31] == b[31]) && (r[31] != a[31]);
  endfunction

  function automatic void sub_flags(logic [31:0] a, logic [31:0] b, logic [31:0] r);
    fz = (r == 0); fn = r[31];
    fc = a > b;
    fv = (a[31] != b[31]) && (r[31] == b[31]);
  endfunction

  // executes one instruction on the predictor state
  function automatic outcome_t execute_instr(instr_t it);
    outcome_t o;
    logic [31:0] a, b, x, y, here, off;
    logic [4:0] vd, v1, v2;
    int k;
    o = '0;
    vd = it.dst[4:0]; v1 = it.s1[4:0]; v2 = it.s2[4:0];
    if (!stop_model) begin
      here = pc_model;
      pc_model = here + 32'd4;
      if (it.op == sveu_pkg::OP_ADD_R || it.op == sveu_pkg::OP_ADD_C) begin
        a = sreg[it.s1];
        b = (it.op == sveu_pkg::OP_ADD_R) ? sreg[it.s2] : {24'd0, it.s2};
        sreg[it.dst] = a + b;
        add_flags(a, b, a + b);
      end else if (it.op == sveu_pkg::OP_SUB_R || it.op == sveu_pkg::OP_SUB_C) begin
        a = sreg[it.s1];
        b = (it.op == sveu_pkg::OP_SUB_R) ? sreg[it.s2] : {24'd0, it.s2};
        sreg[it.dst] = a - b;
        sub_flags(a, b, a - b);
      end else if (it.op == sveu_pkg::OP_MUL_R) begin
        sreg[it.dst] = sreg[it.s1] * sreg[it.s2];
      end else if (it.op == sveu_pkg::OP_MUL_C) begin
        sreg[it.dst] = sreg[it.s1] * {24'd0, it.s2};
      end else if (it.op == sveu_pkg::OP_DIV_R || it.op == sveu_pkg::OP_DIV_C) begin
        b = (it.op == sveu_pkg::OP_DIV_R) ? sreg[it.s2] : {24'd0, it.s2};
        if (b == 0) begin
          o.dz = 1'b1;
          n_zero_div++;
        end else begin
          sreg[it.dst] = quot_trunc(sreg[it.s1], b);
        end
      end else if (it.op == sveu_pkg::OP_MOV_C) begin
        sreg[it.dst] = {24'd0, it.s1};
      end else if (it.op == sveu_pkg::OP_MOV_R) begin
        sreg[it.dst] = sreg[it.s1];
      end else if (it.op == sveu_pkg::OP_REPORT) begin
        o.pv = 1'b1; o.pidx = it.s2; o.pval = sreg[it.s2];
        n_prints++;
      end else if (it.op >= sveu_pkg::OP_VEC_LO && it.op <= sveu_pkg::OP_VEC_HI) begin
        k = (it.op - sveu_pkg::OP_VEC_LO) % 3;
        n_vector++;
        // lanes are independent, so each lane reads its sources before its dest write even if dest aliases them
        for (int i = 0; i < 8; i++) begin
          x = vreg[v1][i];
          y = (it.op <= sveu_pkg::OP_VEC_VHI) ? vreg[v2][i] :
              (it.op <= sveu_pkg::OP_VEC_CHI) ? {24'd0, it.s2} : sreg[it.s2];
          vreg[vd][i] = (k == 0) ? x + y : (k == 1) ? x - y : x * y;
        end
      end else if (it.op == sveu_pkg::OP_HALT) begin
        stop_model = 1'b1;
      end else if (it.op >= sveu_pkg::OP_BR_LO && it.op <= sveu_pkg::OP_BR_HI) begin
        if (branch_taken(4'(it.op - sveu_pkg::OP_BR_LO))) begin
          off = {{24{it.s2[7]}}, it.s2};
          pc_model = here + off * 32'd4;
          n_taken++;
        end
      end else begin
        o.unk = 1'b1;
        stop_model = 1'b1;
      end
    end
    o.pc = pc_model; o.hlt = stop_model;
    o.z = fz; o.n = fn; o.c = fc; o.v = fv;
    return o;
  endfunction

  function automatic instr_t mk(logic [7:0] op, logic [7:0] d, logic [7:0] a,
                                logic [7:0] b);
    instr_t it;
    it.op = op; it.dst = d; it.s1 = a; it.s2 = b; it.drain = 1'b0;
    return it;
  endfunction

  // mostly low registers so values interact, sometimes any index
  function automatic logic [7:0] pick_reg();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it = mk(8'd0, pick_reg(), pick_reg(), pick_reg());
    if (sel < 55) it.op = 8'($urandom_range(sveu_pkg::OP_ADD_R, sveu_pkg::OP_MOV_R));
    else if (sel < 63) it.op = sveu_pkg::OP_REPORT;
    else if (sel < 82) it.op = 8'($urandom_range(sveu_pkg::OP_VEC_LO, sveu_pkg::OP_VEC_HI));
    else it.op = 8'($urandom_range(sveu_pkg::OP_BR_LO, sveu_pkg::OP_BR_HI));
    if ($urandom_range(0, 4) == 0) it.s2 = 8'($urandom);
    if (it.op == sveu_pkg::OP_MOV_C || $urandom_range(0, 5) == 0) it.s1 = 8'($urandom);
    return it;
  endfunction

  // input side: bursts of items with random gaps
  int burst_left = 8, gap_left = 0;
  always @(posedge clk) begin : drive_proc
    instr_t nx;
    logic v_n;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nx = mk(req_type, dest_field, src1_field, src2_field);
        expected_q.push_back(execute_instr(nx));
        n_accepted++;
      end
      v_n = in_valid && in_stall;
      if (!v_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0 &&
                     !(pend_q[0].drain && (expected_q.size() > 0 || in_valid))) begin
          nx = pend_q.pop_front();
          req_type <= nx.op; dest_field <= nx.dst;
          src1_field <= nx.s1; src2_field <= nx.s2;
          v_n = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
      in_valid <= v_n;
    end
  end

  // output side: check results, stall on a shifting pattern
  int hold_left = 0, mode = 0, mode_left = 0;
  always @(posedge clk) begin : monitor_proc
    outcome_t got, want;
    logic st;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {next_pc, print_valid, print_index, print_value, halted, divide_by_zero,
               unknown_opcode, zero_flag, negative_flag, carry_flag, overflow_flag};
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, pc", got.pc, 32'd0);
        end else begin
          want = expected_q.pop_front();
          check_field("next_pc", got.pc, want.pc);
          check_field("print_valid", 32'(got.pv), 32'(want.pv));
          check_field("print_index", 32'(got.pidx), 32'(want.pidx));
          check_field("print_value", got.pval, want.pval);
          check_field("halted", 32'(got.hlt), 32'(want.hlt));
          check_field("divide_by_zero", 32'(got.dz), 32'(want.dz));
          check_field("unknown_opcode", 32'(got.unk), 32'(want.unk));
          check_field("zero_flag", 32'(got.z), 32'(want.z));
          check_field("negative_flag", 32'(got.n), 32'(want.n));
          check_field("carry_flag", 32'(got.c), 32'(want.c));
          check_field("overflow_flag", 32'(got.v), 32'(want.v));
        end
        if (n_results == 300) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        st = (mode == 0) ? 1'b0 : (mode == 1) ? ($urandom_range(0, 3) == 0)
                                              : ($urandom_range(0, 3) != 0);
      end
      out_stall <= st;
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    instr_t it;
    for (int i = 0; i < 256; i++) sreg[i] = '0;
    for (int i = 0; i < 32; i++)
      for (int j = 0; j < 8; j++) vreg[i][j] = '0;
    pc_model = '0; stop_model = 1'b0;
    fz = 0; fn = 0; fc = 0; fv = 0;

    // directed opening: extremes, wraps and divide corners
    pend_q.push_back(mk(sveu_pkg::OP_MOV_C, 8'd1, 8'd255, 8'd0));
    pend_q.push_back(mk(sveu_pkg::OP_MOV_C, 8'd3, 8'd1, 8'd0));
    pend_q.push_back(mk(sveu_pkg::OP_SUB_C, 8'd4, 8'd3, 8'd2));     // r4 = -1
    pend_q.push_back(mk(sveu_pkg::OP_MUL_C, 8'd5, 8'd3, 8'd128));
    pend_q.push_back(mk(sveu_pkg::OP_MUL_R, 8'd5, 8'd5, 8'd5));     // 2^14
    pend_q.push_back(mk(sveu_pkg::OP_MUL_C, 8'd5, 8'd5, 8'd128));
    pend_q.push_back(mk(sveu_pkg::OP_MUL_C, 8'd5, 8'd5, 8'd128));
    pend_q.push_back(mk(sveu_pkg::OP_MUL_C, 8'd5, 8'd5, 8'd2));     // 2^29
    pend_q.push_back(mk(sveu_pkg::OP_DIV_R, 8'd6, 8'd5, 8'd4));     // 2^29 / -1
    pend_q.push_back(mk(sveu_pkg::OP_DIV_R, 8'd7, 8'd4, 8'd200));   // zero divisor reg
    pend_q.push_back(mk(sveu_pkg::OP_DIV_C, 8'd7, 8'd1, 8'd0));     // zero divisor const
    pend_q.push_back(mk(sveu_pkg::OP_DIV_C, 8'd8, 8'd4, 8'd7));     // truncation toward zero
    pend_q.push_back(mk(sveu_pkg::OP_ADD_R, 8'd9, 8'd5, 8'd5));     // r9 = 2^30
    pend_q.push_back(mk(sveu_pkg::OP_SUB_R, 8'd10, 8'd5, 8'd3));    // r10 = 2^29 - 1
    pend_q.push_back(mk(sveu_pkg::OP_ADD_C, 8'd255, 8'd4, 8'd255));
    pend_q.push_back(mk(sveu_pkg::OP_MOV_R, 8'd254, 8'd255, 8'd0));
    pend_q.push_back(mk(sveu_pkg::OP_REPORT, 8'd0, 8'd0, 8'd255));
    pend_q.push_back(mk(sveu_pkg::OP_REPORT, 8'd0, 8'd0, 8'd5));
    pend_q.push_back(mk(sveu_pkg::OP_VADD_C, 8'd255, 8'd63, 8'd255)); // vector index wrap
    pend_q.push_back(mk(sveu_pkg::OP_VMUL_S, 8'd1, 8'd31, 8'd4));
    pend_q.push_back(mk(sveu_pkg::OP_VMUL_V, 8'd2, 8'd1, 8'd31));
    pend_q.push_back(mk(sveu_pkg::OP_VSUB_V, 8'd3, 8'd2, 8'd1));
    pend_q.push_back(mk(sveu_pkg::OP_BR_HI, 8'd0, 8'd0, 8'd128));   // backward branch
    pend_q.push_back(mk(sveu_pkg::OP_BR_HI, 8'd0, 8'd0, 8'd127));
    pend_q.push_back(mk(sveu_pkg::OP_BR_LO, 8'd0, 8'd0, 8'd3));

    // random programs with a full drain in the middle
    for (int i = 0; i < 740; i++) begin
      it = random_instr();
      if (i == 500) it.drain = 1'b1;
      pend_q.push_back(it);
    end

    // stop by halt or unknown opcode, then a few items that must do nothing
    it = ($urandom_range(0, 1) == 0) ? mk(sveu_pkg::OP_HALT, 8'd0, 8'd0, 8'd0)
                                     : mk(8'($urandom_range(sveu_pkg::OP_BR_HI + 1, 255)),
                                          8'($urandom), 8'($urandom), 8'($urandom));
    it.drain = 1'b1;
    pend_q.push_back(it);
    pend_q.push_back(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pend_q.push_back(mk(sveu_pkg::OP_REPORT, 8'd0, 8'd0, 8'd5));
    pend_q.push_back(mk(sveu_pkg::OP_ADD_R, 8'd1, 8'd1, 8'd1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pend_q.size() > 0 || in_valid || expected_q.size() > 0);
    repeat (60) @(posedge clk);

    $display("Ran %0d instructions, %0d results: %0d prints, %0d vector ops,",
             n_accepted, n_results, n_prints, n_vector);
    $display("%0d zero divides, %0d branches taken, stop and post-stop items.",
             n_zero_div, n_taken);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", err_count, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sveu_pkg.sv
rtl/core/sveu_alu.sv
rtl/core/scalar_vector_execute_unit.sv
rtl/core/sveu_checker.sv
verif/scalar_vector_execute_unit_test.sv
